// File: design/fp2rgba_pkg.sv
// Shared types and constants for the float pixel to RGBA8 converter.
package fp2rgba_pkg;

  // Source pixel formats held in the format register
  typedef enum logic [1:0] {
    FMT_RGBA8   = 2'd0,
    FMT_R32F    = 2'd1,
    FMT_RGBA16F = 2'd2,
    FMT_UNSUP   = 2'd3
  } fmt_t;

  // Register indexes on the config port
  localparam logic REG_SOURCE_FORMAT = 1'b0;

  localparam logic [7:0] UNORM8_ONE = 8'hff;

  // Per-stage advance strobes of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_adv_t;

endpackage

// File: design/fp2rgba_f32_conv.sv
// Binary32 to unorm8 converter: scale by 255, round to 24 bits, shift, saturate.
module fp2rgba_f32_conv (
  input  logic                    clk,
  input  fp2rgba_pkg::stage_adv_t adv,
  input  logic [31:0]             bits_in,
  output logic [7:0]              value
);
  import fp2rgba_pkg::*;

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] frac;
  logic [23:0] mant;

  logic        zero_a;
  logic        sat_a;
  logic [31:0] prod_a;
  logic [7:0]  rs_a;

  logic        zero_b;
  logic        sat_b;
  logic [32:0] prod_b;
  logic [7:0]  rs_b;

  logic [23:0] q;
  logic [7:0]  rem;
  logic [7:0]  half;
  logic        up;
  logic [24:0] qr;
  logic [32:0] rounded;
  logic [32:0] shifted;

  assign sign = bits_in[31];
  assign ex   = bits_in[30:23];
  assign frac = bits_in[22:0];
  assign mant = {1'b1, frac};

  // Stage A: classify and form m*255.
  // Subnormals shift out to zero, so they fold into the zero class.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      zero_a <= sign || (ex == 8'hff && frac != 23'd0) || (ex == 8'd0);
      sat_a  <= !sign && (ex >= 8'd127);
      prod_a <= {mant, 8'd0} - {8'd0, mant};
      rs_a   <= 8'd150 - ex;
    end
  end

  // Stage B: normal product has 31 or 32 significant bits; round to 24, ties to even
  always_comb begin
    if (prod_a[31]) begin
      q    = prod_a[31:8];
      rem  = prod_a[7:0];
      half = 8'h80;
    end else begin
      q    = prod_a[30:7];
      rem  = {1'b0, prod_a[6:0]};
      half = 8'h40;
    end
    up = (rem > half) || (rem == half && q[0]);
    qr = {1'b0, q} + {24'd0, up};
    if (prod_a[31]) begin
      rounded = {qr, 8'd0};
    end else begin
      rounded = {1'b0, qr, 7'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      zero_b <= zero_a;
      sat_b  <= sat_a;
      prod_b <= rounded;
      rs_b   <= rs_a;
    end
  end

  // Output side: drop the fraction bits and saturate
  assign shifted = prod_b >> rs_b[5:0];

  always_comb begin
    if (zero_b) begin
      value = 8'd0;
    end else if (sat_b) begin
      value = UNORM8_ONE;
    end else if (rs_b >= 8'd33) begin
      value = 8'd0;
    end else if (shifted > 33'd255) begin
      value = UNORM8_ONE;
    end else begin
      value = shifted[7:0];
    end
  end

endmodule

// File: design/fp2rgba_f16_conv.sv
// Binary16 to unorm8 lane: clamp to [0,1] and give floor(v*255).
module fp2rgba_f16_conv (
  input  logic                    clk,
  input  fp2rgba_pkg::stage_adv_t adv,
  input  logic [15:0]             bits_in,
  output logic [7:0]              value
);
  import fp2rgba_pkg::*;

  logic        sign;
  logic [4:0]  ex;
  logic [9:0]  frac;
  logic [10:0] mant;

  logic        zero_a;
  logic        sat_a;
  logic [18:0] prod_a;
  logic [4:0]  shift_a;
  logic [18:0] shifted;

  logic [7:0]  value_b;

  assign sign = bits_in[15];
  assign ex   = bits_in[14:10];
  assign frac = bits_in[9:0];
  assign mant = (ex == 5'd0) ? {1'b0, frac} : {1'b1, frac};

  // Exponent 31 counts as signed infinity, NaN included
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      zero_a  <= sign;
      sat_a   <= !sign && (ex >= 5'd15);
      prod_a  <= {mant, 8'd0} - {8'd0, mant};
      shift_a <= (ex == 5'd0) ? 5'd24 : 5'd25 - ex;
    end
  end

  assign shifted = prod_a >> shift_a;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      if (zero_a) begin
        value_b <= 8'd0;
      end else if (sat_a) begin
        value_b <= UNORM8_ONE;
      end else begin
        value_b <= shifted[7:0];
      end
    end
  end

  assign value = value_b;

endmodule

// File: design/float_pixel_to_rgba8.sv
// Top level of the raw pixel to RGBA8 converter: config register, pipeline, output.
//
//  port group   dir  content
//  s_*          in   pixel request: tdata = pixel_word[63:0], tlast = last_pixel
//  m_*          out  RGBA8 result: tdata = red, green, blue, alpha; tuser = format_error
//  p*           in   config: source_format at byte address 0
//
// Three register stages; one pixel per cycle while m_tready does not stall the output.
// Stage 1 decodes and scales by 255, stage 2 rounds (binary32) or shifts (binary16),
// stage 3 is the output register.
// rst clears valid bits and the format register; data registers are not reset.
// A stall on m_tready backs up stage by stage; bubbles are squeezed out.
module float_pixel_to_rgba8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] pixel_word
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic        m_tuser,   // [0] format_error
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fp2rgba_pkg::*;

  fmt_t        source_format;
  logic        reg_idx;

  stage_adv_t  adv;
  logic        v1;
  logic        v2;

  fmt_t        fmt1;
  fmt_t        fmt2;
  logic        last1;
  logic        last2;
  logic [31:0] word1;
  logic [31:0] word2;

  logic [7:0]  grey;
  logic [7:0]  lane [4];

  // Config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_RGBA8;
    end else if (psel && penable && pwrite && reg_idx == REG_SOURCE_FORMAT) begin
      source_format <= fmt_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_idx == REG_SOURCE_FORMAT) begin
      prdata = {30'd0, source_format};
    end
  end

  // Pipeline flow control
  assign adv.s3   = !m_tvalid || m_tready;
  assign adv.s2   = !v2 || adv.s3;
  assign adv.s1   = !v1 || adv.s2;
  assign s_tready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1 <= s_tvalid;
      end
      if (adv.s2) begin
        v2 <= v1;
      end
      if (adv.s3) begin
        m_tvalid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      fmt1  <= source_format;
      last1 <= s_tlast;
      word1 <= s_tdata[31:0];
    end
    if (adv.s2) begin
      fmt2  <= fmt1;
      last2 <= last1;
      word2 <= word1;
    end
  end

  fp2rgba_f32_conv u_f32 (
    .clk     (clk),
    .adv     (adv),
    .bits_in (s_tdata[31:0]),
    .value   (grey)
  );

  for (genvar i = 0; i < 4; i++) begin : g_half
    fp2rgba_f16_conv u_f16 (
      .clk     (clk),
      .adv     (adv),
      .bits_in (s_tdata[16*i +: 16]),
      .value   (lane[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      m_tlast <= last2;
      case (fmt2)
        FMT_RGBA8: begin
          m_tdata <= word2;
          m_tuser <= 1'b0;
        end
        FMT_R32F: begin
          m_tdata <= {UNORM8_ONE, grey, grey, grey};
          m_tuser <= 1'b0;
        end
        FMT_RGBA16F: begin
          m_tdata <= {lane[3], lane[2], lane[1], lane[0]};
          m_tuser <= 1'b0;
        end
        default: begin
          m_tdata <= 32'd0;
          m_tuser <= 1'b1;
        end
      endcase
    end
  end

  // Error results carry zero channels
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("format error with nonzero channels");

  // Input is held off only with every stage occupied
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && m_tvalid)
    else $error("input stalled with a free stage");

  // A request in stage 2 fills an empty output register next cycle
  a_fill_out: assert property (@(posedge clk) disable iff (rst)
    v2 && !m_tvalid |=> m_tvalid)
    else $error("bubble not filled at output");

endmodule

// File: tb/testbench.sv
// Testbench for float_pixel_to_rgba8: format register, pixel conversion and stream handshakes.
`timescale 1ns / 1ps

module testbench;
  import fp2rgba_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       format_error;
    logic       last;
  } rgba_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [63:0] pixel_word
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic        m_tuser;        // [0] format_error
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgba_result_t pending_pixels[$];
  rgba_result_t oldest_pixel;
  fmt_t         active_format = FMT_RGBA8;
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;
  int           error_count = 0;
  int           results_checked = 0;
  int           pixels_per_format[4] = '{0, 0, 0, 0};

  localparam int        PIPE_SETTLE = 8;
  localparam int        HOLD_CYCLES = 150;
  localparam logic [2:0] FORMAT_ADDR = {REG_SOURCE_FORMAT, 2'b00};

  float_pixel_to_rgba8 dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // binary32 -> unorm8: m*255 rounded to 24 significant bits (ties to even), then truncated
  function automatic logic [7:0] f32_to_unorm8(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [63:0] m, p, q, rem, halfway;
    int          e, len, sh, rs;
    ex = bits[30:23];
    frac = bits[22:0];
    if (ex == 8'hff) return (frac != 0 || bits[31]) ? 8'h00 : UNORM8_ONE;
    if (bits[31]) return 8'h00;
    if (ex >= 8'd127) return UNORM8_ONE;
    if (ex == 8'd0) begin
      m = {41'd0, frac};
      e = 1;
    end else begin
      m = {40'd0, 1'b1, frac};
      e = ex;
    end
    p = m * 64'd255;
    if (p == 0) return 8'h00;
    len = 0;
    while (len < 64 && (p >> len) != 0) len++;
    if (len > 24) begin
      sh = len - 24;
      q = p >> sh;
      rem = p & ((64'd1 << sh) - 64'd1);
      halfway = 64'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) q++;
      p = q << sh;
    end
    rs = 150 - e;
    if (rs >= 64) return 8'h00;
    p = p >> rs;
    return (p > 64'd255) ? UNORM8_ONE : p[7:0];
  endfunction

  // binary16 -> unorm8; exponent 31 counts as signed infinity, NaN included
  function automatic logic [7:0] f16_to_unorm8(input logic [15:0] h);
    logic [4:0]  ex;
    logic [31:0] m;
    int          e;
    ex = h[14:10];
    if (ex == 5'd31) return h[15] ? 8'h00 : UNORM8_ONE;
    if (h[15]) return 8'h00;
    if (ex >= 5'd15) return UNORM8_ONE;
    if (ex == 5'd0) begin
      m = {22'd0, h[9:0]};
      e = 1;
    end else begin
      m = 32'd1024 + h[9:0];
      e = ex;
    end
    m = (m * 32'd255) >> (25 - e);
    return m[7:0];
  endfunction

  function automatic rgba_result_t convert_pixel(input fmt_t fmt, input logic [63:0] word,
                                                 input logic last);
    rgba_result_t r;
    r.red = 8'h00;
    r.green = 8'h00;
    r.blue = 8'h00;
    r.alpha = 8'h00;
    r.format_error = 1'b0;
    r.last = last;
    case (fmt)
      FMT_RGBA8: begin
        r.red = word[7:0];
        r.green = word[15:8];
        r.blue = word[23:16];
        r.alpha = word[31:24];
      end
      FMT_R32F: begin
        r.red = f32_to_unorm8(word[31:0]);
        r.green = r.red;
        r.blue = r.red;
        r.alpha = UNORM8_ONE;
      end
      FMT_RGBA16F: begin
        r.red = f16_to_unorm8(word[15:0]);
        r.green = f16_to_unorm8(word[31:16]);
        r.blue = f16_to_unorm8(word[47:32]);
        r.alpha = f16_to_unorm8(word[63:48]);
      end
      default: r.format_error = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] random_f32();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        f[31] = 1'b0;
        f[30:23] = 8'($urandom_range(110, 126));
      end
      4: begin
        // low product byte lands exactly halfway when the product has 32 bits: exercises ties to even
        f[31] = 1'b0;
        f[30:23] = 8'($urandom_range(118, 126));
        f[7:0] = 8'h80;
      end
      5: begin
        f[31] = 1'b0;
        f[30:23] = 8'($urandom_range(127, 130));
      end
      6: begin
        f[30:23] = 8'hff;
        if ($urandom_range(0, 1) == 0) f[22:0] = '0;
      end
      7: begin
        f[31] = 1'b0;
        f[30:23] = 8'h00;
      end
      8: f[31] = 1'b1;
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [15:0] random_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        h[15] = 1'b0;
        h[14:10] = 5'($urandom_range(0, 14));
      end
      6: begin
        h[15] = 1'b0;
        h[14:10] = 5'($urandom_range(15, 31));
      end
      7: h[15] = 1'b1;
      8: begin
        h[15] = 1'b0;
        h[14:10] = 5'd0;
      end
      default: ;
    endcase
    return h;
  endfunction

  function automatic logic [63:0] random_pixel(input fmt_t fmt);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (fmt == FMT_R32F) w[31:0] = random_f32();
    if (fmt == FMT_RGBA16F) begin
      for (int i = 0; i < 4; i++) w[16*i +: 16] = random_half();
    end
    return w;
  endfunction

  // receiver: random stalls, or a counted hold-off when one is armed
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h", $time, m_tdata);
        error_count++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        check_field("red", oldest_pixel.red, m_tdata[7:0]);
        check_field("green", oldest_pixel.green, m_tdata[15:8]);
        check_field("blue", oldest_pixel.blue, m_tdata[23:16]);
        check_field("alpha", oldest_pixel.alpha, m_tdata[31:24]);
        check_field("format_error", oldest_pixel.format_error, m_tuser);
        check_field("last", oldest_pixel.last, m_tlast);
        results_checked++;
      end
    end
  end

  task automatic push_pixel(input logic [63:0] word, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_pixels.push_back(convert_pixel(active_format, word, last));
    pixels_per_format[active_format]++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // bus returns to idle between accesses
    @(posedge clk);
  endtask

  task automatic set_format(input fmt_t fmt);
    logic [31:0] unused;
    wait_idle();
    apb_access(1'b1, FORMAT_ADDR, {30'd0, fmt}, unused);
    active_format = fmt;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  task automatic reset_dut();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_format_register();
    fmt_t        fmts[4];
    logic [31:0] readback;
    fmts = '{FMT_UNSUP, FMT_RGBA16F, FMT_R32F, FMT_RGBA8};
    // reset value first
    apb_access(1'b0, FORMAT_ADDR, 32'd0, readback);
    check_field("source_format after reset", FMT_RGBA8, readback);
    foreach (fmts[i]) begin
      set_format(fmts[i]);
      apb_access(1'b0, FORMAT_ADDR, 32'd0, readback);
      check_field("source_format readback", fmts[i], readback);
    end
  endtask

  task automatic test_directed_pixels();
    set_idling(0, 0);
    set_format(FMT_RGBA8);
    push_pixel(64'h0000_0000_0000_0000, 1'b0);
    push_pixel(64'hffff_ffff_ffff_ffff, 1'b1);

    set_format(FMT_R32F);
    push_pixel(64'h0000_0000_0000_0000, 1'b0);   // +0
    push_pixel(64'hffff_ffff_8000_0000, 1'b0);   // -0, high word ignored
    push_pixel(64'h0000_0000_3f80_0000, 1'b0);   // exactly one
    push_pixel(64'h0000_0000_7f80_0000, 1'b0);   // +inf
    push_pixel(64'h0000_0000_7fc0_0000, 1'b0);   // NaN
    push_pixel(64'h0000_0000_ff80_0000, 1'b0);   // -inf
    push_pixel(64'h0000_0000_3f7f_ffff, 1'b0);   // just below one
    push_pixel(64'h0000_0000_0000_0001, 1'b0);   // smallest subnormal
    push_pixel(64'h0000_0000_3f00_0000, 1'b0);   // one half
    push_pixel(64'h0000_0000_bf00_0000, 1'b0);   // negative
    push_pixel(64'h0000_0000_7f7f_ffff, 1'b1);   // max finite

    set_format(FMT_RGBA16F);
    push_pixel(64'h7c00_8000_0000_3c00, 1'b0);   // one, +0, -0, +inf
    push_pixel(64'h0001_3bff_fe00_7e00, 1'b0);   // NaN, -NaN, below one, subnormal
    push_pixel(64'h03ff_0400_bc00_7bff, 1'b1);   // max finite, negative, min normal, max subnormal

    set_format(FMT_UNSUP);
    push_pixel(64'hffff_ffff_ffff_ffff, 1'b1);
  endtask

  // output held off while the sender keeps going: pipeline fills and s_tready drops
  task automatic test_backpressure();
    set_format(FMT_RGBA16F);
    set_idling(0, 0);
    hold_left = HOLD_CYCLES;
    repeat (40) push_pixel(random_pixel(active_format), $urandom_range(0, 7) == 0);
    wait_idle();
  endtask

  task automatic test_random_pixels();
    int   idle_mix[4][2];
    fmt_t fmts[4];
    idle_mix = '{'{0, 0}, '{64, 0}, '{0, 64}, '{6, 6}};
    fmts = '{FMT_RGBA8, FMT_R32F, FMT_RGBA16F, FMT_UNSUP};
    foreach (idle_mix[p]) begin
      set_idling(idle_mix[p][0], idle_mix[p][1]);
      foreach (fmts[f]) begin
        set_format(fmts[f]);
        repeat (fmts[f] == FMT_UNSUP ? 40 : 110)
          push_pixel(random_pixel(active_format), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin
    reset_dut();
    test_format_register();
    test_directed_pixels();
    test_backpressure();
    test_random_pixels();
    wait_idle();
    $display("checked %0d pixels: rgba8 %0d, r32f %0d, rgba16f %0d, unsupported %0d",
             results_checked, pixels_per_format[FMT_RGBA8], pixels_per_format[FMT_R32F],
             pixels_per_format[FMT_RGBA16F], pixels_per_format[FMT_UNSUP]);
    $display("four idle/stall mixes, a %0d-cycle output hold-off, %0d errors",
             HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending_pixels.size());
    $display("status: fail");
    $finish;
  end

endmodule
